// ----- hw/rtl/http_response_header_splitter_defines.svh -----
// Assertion macros used by the header splitter top level.
`ifndef HTTP_RESPONSE_HEADER_SPLITTER_DEFINES_SVH
`define HTTP_RESPONSE_HEADER_SPLITTER_DEFINES_SVH

`ifndef SYNTHESIS

// Implication checked on every rising clock edge outside reset.
`define HRS_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("header splitter check failed");

// Implication with the consequent in the next cycle.
`define HRS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("header splitter check failed");

`else

`define HRS_ASSERT_IMPLY(lbl, ante, cons)
`define HRS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hw/rtl/hrs_pkg.sv -----
// Shared types and constants of the HTTP response header splitter.
`timescale 1ns / 1ps

package hrs_pkg;

   localparam int CFG_W = 13;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BODY   = 2'd0,
      KIND_HEADER = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   // Error codes
   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_TOO_LARGE = 3'd1,
      ERR_BAD_LINE  = 3'd2,
      ERR_STATUS    = 3'd3,
      ERR_EARLY_END = 3'd4
   } err_type;

   // One result word from the parser
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] body;
      logic [9:0] status;
      err_type    err;
      logic       last;
   } result_type;

   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [9:0] STATUS_LOW  = 10'd200;
   localparam logic [9:0] STATUS_HIGH = 10'd300;
   localparam int         PREFIX_LEN  = 5;
   localparam int         HEADER_MIN  = 12;

   localparam logic [CFG_W-1:0] LIMIT_RESET = 13'd4096;

   // Protocol prefix "HTTP/"
   function automatic logic [7:0] proto_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0:    c = 8'h48;
         3'd1:    c = 8'h54;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h50;
         default: c = 8'h2F;
      endcase
      return c;
   endfunction

endpackage

// ----- hw/rtl/hrs_parser.sv -----
// Per-byte header parser state and result logic.
`timescale 1ns / 1ps

module hrs_parser
   import hrs_pkg::*;
#(
   parameter int HEADER_BYTES_MAX = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       data_byte,
   input  logic             end_of_stream,
   input  logic [CFG_W-1:0] header_limit,
   output result_type       result
);

   localparam int LIM_W = $clog2(HEADER_BYTES_MAX + 1);
   localparam int CNT_W = (LIM_W < CFG_W) ? LIM_W : CFG_W;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_DRAIN  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      SL_SEEK   = 2'd0,
      SL_DIGITS = 2'd1,
      SL_OK     = 2'd2,
      SL_BAD    = 2'd3
   } sl_type;

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [1:0]       term_ff, term_in;
   logic             prefix_ff, prefix_in;
   sl_type           sl_ff, sl_in;
   logic [1:0]       digits_ff, digits_in;
   logic [9:0]       acc_ff, acc_in;

   logic [CNT_W-1:0] limit;
   logic [13:0]      acc_wide;
   logic             found;

   // Limit in force: smaller of register and build-time maximum
   always_comb begin
      if (32'(header_limit) > 32'(HEADER_BYTES_MAX)) begin
         limit = CNT_W'(HEADER_BYTES_MAX);
      end else begin
         limit = CNT_W'(header_limit);
      end
   end

   // Next state and result for the byte at hand
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      term_in   = term_ff;
      prefix_in = prefix_ff;
      sl_in     = sl_ff;
      digits_in = digits_ff;
      acc_in    = acc_ff;
      found     = 1'b0;
      acc_wide  = {acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                + {6'd0, data_byte - CHAR_ZERO};
      result    = '0;
      result.last = end_of_stream;

      unique case (phase_ff)
         PH_BODY: begin
            result.valid = 1'b1;
            result.kind  = KIND_BODY;
            result.body  = data_byte;
         end
         PH_HEADER: begin
            if (count_ff >= limit) begin
               result.valid = 1'b1;
               result.kind  = KIND_ERROR;
               result.err   = ERR_TOO_LARGE;
               phase_in     = PH_DRAIN;
            end else begin
               count_in = count_ff + 1'b1;

               // prefix check over the first bytes
               if (count_ff < CNT_W'(PREFIX_LEN) &&
                   data_byte != proto_char(count_ff[2:0])) begin
                  prefix_in = 1'b0;
               end

               // status line: space, then three digits
               unique case (sl_ff)
                  SL_SEEK: begin
                     if (data_byte == CHAR_SPACE) begin
                        sl_in = SL_DIGITS;
                     end else if (data_byte == CHAR_CR || data_byte == CHAR_LF) begin
                        sl_in = SL_BAD;
                     end
                  end
                  SL_DIGITS: begin
                     if (data_byte >= CHAR_ZERO && data_byte <= CHAR_NINE) begin
                        acc_in    = acc_wide[9:0];
                        digits_in = digits_ff + 1'b1;
                        if (digits_ff >= 2'd2) begin
                           sl_in = SL_OK;
                        end
                     end else begin
                        sl_in = SL_BAD;
                     end
                  end
                  default: begin
                  end
               endcase

               // CR LF CR LF tracker
               unique case (term_ff)
                  2'd0: term_in = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
                  2'd1: term_in = (data_byte == CHAR_LF) ? 2'd2 :
                                  (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
                  2'd2: term_in = (data_byte == CHAR_CR) ? 2'd3 : 2'd0;
                  default: begin
                     found   = (data_byte == CHAR_LF);
                     term_in = (data_byte == CHAR_CR) ? 2'd1 : 2'd0;
                  end
               endcase

               // header end index is new count minus four
               priority if (found) begin
                  result.valid = 1'b1;
                  if (count_ff < CNT_W'(HEADER_MIN + 3) || !prefix_in || sl_in != SL_OK) begin
                     result.kind = KIND_ERROR;
                     result.err  = ERR_BAD_LINE;
                     phase_in    = PH_DRAIN;
                  end else if (acc_in < STATUS_LOW || acc_in >= STATUS_HIGH) begin
                     result.kind   = KIND_ERROR;
                     result.err    = ERR_STATUS;
                     result.status = acc_in;
                     phase_in      = PH_DRAIN;
                  end else begin
                     result.kind   = KIND_HEADER;
                     result.status = acc_in;
                     phase_in      = PH_BODY;
                  end
               end else if (end_of_stream) begin
                  result.valid = 1'b1;
                  result.kind  = KIND_ERROR;
                  result.err   = ERR_EARLY_END;
               end else begin
               end
            end
         end
         default: begin
         end
      endcase
   end

   // State registers; the end mark starts a new stream in every phase
   always_ff @(posedge clock) begin
      if (reset || (step && end_of_stream)) begin
         phase_ff  <= PH_HEADER;
         count_ff  <= '0;
         term_ff   <= 2'd0;
         prefix_ff <= 1'b1;
         sl_ff     <= SL_SEEK;
         digits_ff <= 2'd0;
         acc_ff    <= 10'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         term_ff   <= term_in;
         prefix_ff <= prefix_in;
         sl_ff     <= sl_in;
         digits_ff <= digits_in;
         acc_ff    <= acc_in;
      end
   end

endmodule

// ----- hw/rtl/http_response_header_splitter.sv -----
// HTTP response header splitter: top level with input and result registers.
`timescale 1ns / 1ps
`include "http_response_header_splitter_defines.svh"

// Takes one response byte per word on req_ and emits at most one result per
// byte on rsp_: a header-accepted word with the status code, then each body
// byte, or one error word after which the rest of the stream up to the end
// mark is dropped. Throughput is one byte per cycle unless rsp_ stalls.
// A byte is held in the input register and parsed from there into the result
// register, which drives rsp_. The parser steps only when the result register
// is empty or being read, so a stalled result stops the input register and
// req_tready drops once it is full. The header size limit is the smaller of
// csr_wdata's last written value (4096 after reset) and HEADER_BYTES_MAX;
// write it only between streams. No clearing pass is needed after reset.
module http_response_header_splitter
   import hrs_pkg::*;
#(
   parameter int HEADER_BYTES_MAX = 4096
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tlast,   // end_of_stream
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] body_byte, [17:8] status_code,
                                         // [20:18] error_code, [23:21] zero
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // last
);

   logic [CFG_W-1:0] limit_ff;
   logic             in_valid_ff;
   logic [7:0]       in_byte_ff;
   logic             in_eos_ff;
   logic             out_valid_ff;
   result_type       out_res_ff;
   result_type       res;
   logic             step;

   // Byte in the input register moves on when the result register is free
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   // Limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         limit_ff <= csr_wdata;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (step) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eos_ff  <= req_tlast;
      end
   end

   hrs_parser #(
      .HEADER_BYTES_MAX(HEADER_BYTES_MAX)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .end_of_stream(in_eos_ff),
      .header_limit (limit_ff),
      .result       (res)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step && res.valid) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_res_ff.err, out_res_ff.status, out_res_ff.body};
   assign rsp_tuser  = out_res_ff.kind;
   assign rsp_tlast  = out_res_ff.last;

   // Checks
   `HRS_ASSERT_IMPLY(a_body_no_err, rsp_tvalid && out_res_ff.kind == KIND_BODY,
                     out_res_ff.err == ERR_NONE && out_res_ff.status == 10'd0)
   `HRS_ASSERT_IMPLY(a_err_has_code, rsp_tvalid && out_res_ff.kind == KIND_ERROR,
                     out_res_ff.err != ERR_NONE && out_res_ff.body == 8'd0)
   `HRS_ASSERT_IMPLY(a_hdr_success, rsp_tvalid && out_res_ff.kind == KIND_HEADER,
                     out_res_ff.status >= STATUS_LOW && out_res_ff.status < STATUS_HIGH)
   `HRS_ASSERT_IMPLY(a_ready_when_empty, !in_valid_ff, req_tready)
   `HRS_ASSERT_NEXT(a_stall_holds_result, rsp_tvalid && !rsp_tready,
                    rsp_tvalid && $stable(out_res_ff))

endmodule
